// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ghost point relaxed Jacobi RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on clk and disabled in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gpj_pkg.sv =====
// Shared types, constants and saturation helper for the ghost point Jacobi block.
`timescale 1ns / 1ps
package gpj_pkg;

  localparam int COMPONENTS_DEF = 3;
  localparam int STENCIL_TAPS = 4;
  localparam int DIV_W = 48;
  localparam int DIVISOR_W = 47;

  // Input kinds.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_SOLVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_COARSE_GAIN = 2'd0;
  localparam logic [1:0] REG_FINE_GAIN   = 2'd1;
  localparam logic [1:0] REG_RELAX       = 2'd2;

  // Sequencer steps of the shared multiplier.
  localparam logic [2:0] STEP_P0 = 3'd0;
  localparam logic [2:0] STEP_P1 = 3'd1;
  localparam logic [2:0] STEP_P2 = 3'd2;
  localparam logic [2:0] STEP_P3 = 3'd3;
  localparam logic [2:0] STEP_B  = 3'd4;
  localparam logic [2:0] STEP_A  = 3'd5;
  localparam logic [2:0] STEP_RQ = 3'd6;
  localparam logic [2:0] STEP_RO = 3'd7;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
  localparam logic [17:0] ONE_Q16 = 18'd65536;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic               ov;
    logic signed [31:0] v;
  } sat_t;

  // Clamp a wide signed value to 32 bits and report the clamp.
  function automatic sat_t sat32(input logic signed [65:0] x);
    sat_t r;
    if (x > SAT_HI) begin
      r.ov = 1'b1;
      r.v  = 32'sh7fffffff;
    end else if (x < SAT_LO) begin
      r.ov = 1'b1;
      r.v  = 32'sh80000000;
    end else begin
      r.ov = 1'b0;
      r.v  = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/gpj_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpj_div
  import gpj_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_W-1:0]     quotient
);

  localparam int CW = $clog2(DIV_W);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIV_W-1:0]     work;
  logic [CW-1:0]        cnt;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] trial;
  logic                 ge;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem, work[DIV_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr};
    ge      = ~trial[DIVISOR_W+1];
  end

  // Control: count the quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend shift register that fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      work <= dividend;
    end else if (busy) begin
      rem  <= ge ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      work <= {work[DIV_W-2:0], ge};
    end
  end

  assign quotient = work;

  `ASSERT_NEXT(a_done_after_busy, busy && cnt == CW'(DIV_W - 1) && !start, done, "divider did not finish")
  `ASSERT_IMPL(a_done_not_busy, done, !busy || start, "divider busy while done")
  `ASSERT_IMPL(a_cnt_range, busy, cnt <= CW'(DIV_W - 1), "divider count out of range")

endmodule

// ===== rtl/core/ghost_point_relaxed_jacobi.sv =====
// Top level: sequencer, shared multiplier, stencil windows and registers.
//
//  channel | dir | handshake                  | word
//  s_*     | in  | tvalid/tready              | tdata: solve/push operands, tuser: kind, comp
//  m_*     | out | tvalid/tready              | tdata: new_ghost, residual_max, tuser: flag
//  APB     | in  | psel/penable/pwrite/pready | coarse_gain, fine_gain, relax_factor
//
// A push or clear word is handled in the idle state. A solve with a nonzero divisor runs
// eight multiply/accumulate steps, each a multiply and an accumulate state, on the one 33x33
// multiplier, then the divide state (48 quotient bits, then the quotient is taken),
// and a final state for change tracking. A zero divisor skips the divider.
// Reset clears windows, maxima and registers at once; no clearing pass is needed.
// The input is ready only while the sequencer is idle; a solve waits at its last
// step while the previous result has not been taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ghost_point_relaxed_jacobi
  import gpj_pkg::*;
#(
  parameter int COMPONENTS = COMPONENTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] coarse_disp, [62:32] coarse_mod, [94:63] next_coarse,
  // [126:95] next_fine, [157:127] fine_mod, [189:158] old_ghost, rest zero
  input  logic [191:0] s_tdata,
  // [1:0] kind, [3:2] component
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] new_ghost, [62:32] residual_max, [63] zero
  output logic [63:0]  m_tdata,
  // [0] saturated
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CIW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  // Configuration registers.
  logic signed [31:0] coarse_gain;
  logic signed [31:0] fine_gain;
  logic [17:0]        relax_factor;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coarse_gain  <= '0;
      fine_gain    <= 32'sd65536;
      relax_factor <= ONE_Q16;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_COARSE_GAIN: coarse_gain  <= pwdata;
        REG_FINE_GAIN:   fine_gain    <= pwdata;
        REG_RELAX:       relax_factor <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COARSE_GAIN: prdata = coarse_gain;
      REG_FINE_GAIN:   prdata = fine_gain;
      REG_RELAX:       prdata = {14'd0, relax_factor};
      default:         prdata = '0;
    endcase
  end

  // Input field unpacking.
  logic [1:0]         in_kind;
  logic [1:0]         in_comp;
  logic signed [31:0] in_cdisp;
  logic [30:0]        in_cmod;
  logic               accept;
  logic               comp_ok;

  assign in_kind  = s_tuser[1:0];
  assign in_comp  = s_tuser[3:2];
  assign in_cdisp = s_tdata[31:0];
  assign in_cmod  = s_tdata[62:32];
  assign comp_ok  = 32'(in_comp) < COMPONENTS;

  // State.
  state_t             state;
  logic [2:0]         step;
  logic [CIW-1:0]     comp;
  logic signed [31:0] next_coarse;
  logic signed [31:0] next_fine;
  logic [30:0]        fine_mod;
  logic signed [31:0] old_ghost;
  logic signed [31:0] disp_win [COMPONENTS][STENCIL_TAPS];
  logic [30:0]        mod_win  [COMPONENTS][STENCIL_TAPS];
  logic [30:0]        change_max [COMPONENTS];
  logic signed [65:0] prod;
  logic signed [52:0] acc;
  logic signed [31:0] b_val;
  logic signed [47:0] a_val;
  logic signed [31:0] q_val;
  logic signed [31:0] nw;
  logic               flag;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Shared multiplier operand selection.
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  sat_t               t_sat;

  always_comb begin
    t_sat = sat32(66'($signed(acc[52:4])));
    unique case (step)
      STEP_P0, STEP_P1, STEP_P2, STEP_P3: begin
        ma = 33'(disp_win[comp][step[1:0]]);
        mb = {2'b00, mod_win[comp][step[1:0]]};
      end
      STEP_B: begin
        ma = 33'(coarse_gain);
        mb = 33'(t_sat.v);
      end
      STEP_A: begin
        ma = 33'(fine_gain);
        mb = {2'b00, fine_mod};
      end
      STEP_RQ: begin
        ma = {15'd0, relax_factor};
        mb = 33'(q_val);
      end
      default: begin
        ma = $signed({15'd0, ONE_Q16}) - $signed({15'd0, relax_factor});
        mb = 33'(old_ghost);
      end
    endcase
  end

  // Accumulate terms of the current step.
  logic signed [49:0] ps;
  logic signed [52:0] term;
  logic signed [65:0] b_wide;
  logic signed [65:0] sum_wide;
  sat_t               b_sat;
  sat_t               nw_sat;

  always_comb begin
    ps = prod[65:16];
    unique case (step)
      STEP_P1, STEP_P2: term = 53'(ps) + (53'(ps) <<< 3);
      default:          term = -53'(ps);
    endcase
    b_wide   = 66'(next_coarse) + 66'(ps) - 66'(next_fine);
    b_sat    = sat32(b_wide);
    sum_wide = 66'(acc) + prod;
    nw_sat   = sat32(66'($signed(sum_wide[65:16])));
  end

  // Divider operands and result handling.
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [32:0]        b_mag;
  logic [DIVISOR_W-1:0] a_mag;
  logic signed [47:0] a_next;
  logic               q_neg;
  logic signed [65:0] q_wide;
  sat_t               q_sat;

  always_comb begin
    a_next    = prod[63:16];
    b_mag     = b_val[31] ? 33'd0 - 33'($signed(b_val)) : 33'(b_val);
    // The divisor is taken straight from the product, in the cycle it is formed.
    a_mag     = a_next[47] ? DIVISOR_W'(48'd0 - a_next) : DIVISOR_W'(a_next);
    q_neg     = b_val[31] ^ a_val[47];
    q_wide    = q_neg ? 66'd0 - 66'(div_q) : 66'(div_q);
    q_sat     = sat32(q_wide);
    div_start = (state == ST_ACC) && (step == STEP_A) && (a_next != '0);
  end

  gpj_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({b_mag[31:0], 16'd0}),
    .divisor  (a_mag),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Change magnitude for the running maximum.
  logic signed [32:0] diff;
  logic [32:0]        chg_mag;
  logic [30:0]        chg;
  logic               chg_ov;
  logic               out_free;

  always_comb begin
    diff     = 33'(nw) - 33'(old_ghost);
    chg_mag  = diff[32] ? 33'd0 - diff : diff;
    chg_ov   = chg_mag > 33'h7fffffff;
    chg      = chg_ov ? 31'h7fffffff : chg_mag[30:0];
    out_free = !m_tvalid || m_tready;
  end

  // Sequencer, windows and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= STEP_P0;
      m_tvalid <= 1'b0;
      for (int c = 0; c < COMPONENTS; c++) begin
        change_max[c] <= '0;
        for (int k = 0; k < STENCIL_TAPS; k++) begin
          disp_win[c][k] <= '0;
          mod_win[c][k]  <= '0;
        end
      end
    end else begin
      if (m_tvalid && m_tready && !(state == ST_FIN && out_free)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_kind == KIND_CLEAR) begin
              for (int c = 0; c < COMPONENTS; c++) change_max[c] <= '0;
            end else if (in_kind == KIND_PUSH && comp_ok) begin
              for (int k = 0; k < STENCIL_TAPS - 1; k++) begin
                disp_win[CIW'(in_comp)][k] <= disp_win[CIW'(in_comp)][k+1];
                mod_win[CIW'(in_comp)][k]  <= mod_win[CIW'(in_comp)][k+1];
              end
              disp_win[CIW'(in_comp)][STENCIL_TAPS-1] <= in_cdisp;
              mod_win[CIW'(in_comp)][STENCIL_TAPS-1]  <= in_cmod;
            end else if (in_kind == KIND_SOLVE && comp_ok) begin
              state <= ST_MUL;
              step  <= STEP_P0;
            end
          end
        end
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          state <= ST_MUL;
          step  <= step + 1'b1;
          unique case (step)
            STEP_P0:          acc <= term;
            STEP_P1, STEP_P2: acc <= acc + term;
            STEP_P3:          acc <= acc + term;
            STEP_A: begin
              if (a_next == '0) begin
                q_val <= b_val[31] ? 32'sh80000000 : 32'sh7fffffff;
              end else begin
                state <= ST_DIV;
              end
            end
            STEP_RQ: acc <= 53'(prod);
            STEP_RO: state <= ST_FIN;
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            q_val <= q_sat.v;
            state <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
            step     <= STEP_P0;
            if (chg > change_max[comp]) change_max[comp] <= chg;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      comp        <= CIW'(in_comp);
      next_coarse <= s_tdata[94:63];
      next_fine   <= s_tdata[126:95];
      fine_mod    <= s_tdata[157:127];
      old_ghost   <= s_tdata[189:158];
      flag        <= 1'b0;
    end
    if (state == ST_MUL) prod <= ma * mb;
    if (state == ST_MUL && step == STEP_B && t_sat.ov) flag <= 1'b1;
    if (state == ST_ACC) begin
      unique case (step)
        STEP_B: begin
          b_val <= b_sat.v;
          if (b_sat.ov) flag <= 1'b1;
        end
        STEP_A: begin
          a_val <= a_next;
          if (a_next == '0) flag <= 1'b1;
        end
        STEP_RO: begin
          nw <= nw_sat.v;
          if (nw_sat.ov) flag <= 1'b1;
        end
        default: ;
      endcase
    end
    if (state == ST_DIV && div_done && q_sat.ov) flag <= 1'b1;
    if (state == ST_FIN && out_free) begin
      m_tdata <= {1'b0, (chg > change_max[comp]) ? chg : change_max[comp], nw};
      m_tuser <= flag || chg_ov;
    end
  end

  `ASSERT_IMPL(a_ready_idle, s_tready, state == ST_IDLE, "input ready outside idle")
  `ASSERT_IMPL(a_div_in_div, state == ST_DIV, div_busy || div_done, "divider idle in divide state")
  `ASSERT_IMPL(a_div_start, div_start, state == ST_ACC && step == STEP_A, "divider started late")
  `ASSERT_NEXT(a_fin_out, state == ST_FIN && out_free, m_tvalid, "result not presented")

endmodule
